// File: rtl/chpc_pkg.sv
// shared constants and types of the constrained height path counter
package chpc_pkg;

	localparam int unsigned MAX_COLUMNS = 4096;
	localparam int unsigned DEPTH       = MAX_COLUMNS / 2;
	localparam int unsigned AW          = $clog2(DEPTH);
	localparam int unsigned IDXW        = $clog2(MAX_COLUMNS);
	localparam int unsigned CW          = 30;
	localparam int unsigned COLW        = 13;
	localparam int unsigned HW          = 12;

	localparam logic [CW-1:0] PRIME = 30'd1000000007;

	typedef enum logic [1:0] {
		MODE_START,
		MODE_FREE,
		MODE_FIXED
	} sweep_mode_t;

	typedef struct packed {
		sweep_mode_t   mode;
		logic [AW-1:0] last_idx;
		logic [AW-1:0] hi;
		logic [AW-1:0] cap;
		logic [AW-1:0] tgt;
	} sweep_cmd_t;

	typedef struct packed {
		logic          done;
		logic [CW-1:0] res0;
	} sweep_sts_t;

endpackage

// File: rtl/chpc_sweep.sv
// count memory and the read-modify-write sweep over it
module chpc_sweep (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  chpc_pkg::sweep_cmd_t   cmd,
	output chpc_pkg::sweep_sts_t   sts
);

	localparam logic [chpc_pkg::CW+1:0] P1 = {2'b00, chpc_pkg::PRIME};
	localparam logic [chpc_pkg::CW+1:0] P2 = P1 << 1;

	function automatic logic [chpc_pkg::CW-1:0] mod_fold(input logic [chpc_pkg::CW+1:0] s);
		logic [chpc_pkg::CW+1:0] r;
		begin
			r = s;
			if (s >= P2) begin
				r = s - P2;
			end else if (s >= P1) begin
				r = s - P1;
			end
			return r[chpc_pkg::CW-1:0];
		end
	endfunction

	logic [chpc_pkg::CW-1:0] mem_q [chpc_pkg::DEPTH];

	chpc_pkg::sweep_cmd_t      cmd_q;
	logic                      issuing_q;
	logic [chpc_pkg::AW:0]     rd_idx_q;
	logic                      rd_stop;
	logic                      rd_mask;

	logic                      valid_s1;
	logic [chpc_pkg::AW:0]     idx_s1;
	logic [chpc_pkg::AW:0]     idx_m1;
	logic                      mask_s1;
	logic [chpc_pkg::CW-1:0]   rdata_s1;
	logic [chpc_pkg::CW-1:0]   c_val;
	logic [chpc_pkg::CW-1:0]   prev_q;
	logic [chpc_pkg::CW-1:0]   cur_q;

	logic                      valid_s2;
	logic [chpc_pkg::AW-1:0]   widx_s2;
	logic [chpc_pkg::CW+1:0]   sum_s2;
	logic [chpc_pkg::CW-1:0]   red;
	logic [chpc_pkg::CW-1:0]   wval;

	logic                      done_q;
	logic [chpc_pkg::CW-1:0]   res0_q;

	// reads beyond the written extent or the cap count as zero
	assign rd_mask = (rd_idx_q <= {1'b0, cmd_q.hi}) && (rd_idx_q <= {1'b0, cmd_q.cap});
	assign rd_stop = (rd_idx_q == ({1'b0, cmd_q.last_idx} + 1'b1));
	assign c_val   = mask_s1 ? rdata_s1 : '0;
	assign idx_m1  = idx_s1 - 1'b1;
	assign red     = mod_fold(sum_s2);

	always_comb begin
		case (cmd_q.mode)
			chpc_pkg::MODE_START: wval = (widx_s2 == '0) ? chpc_pkg::CW'(1) : '0;
			chpc_pkg::MODE_FREE:  wval = (widx_s2 <= cmd_q.cap) ? red : '0;
			chpc_pkg::MODE_FIXED: wval = (widx_s2 == cmd_q.tgt) ? red : '0;
			default:              wval = '0;
		endcase
	end

	// memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (valid_s2) begin
			mem_q[widx_s2] <= wval;
		end
		rdata_s1 <= mem_q[rd_idx_q[chpc_pkg::AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issuing_q <= 1'b0;
			rd_idx_q  <= '0;
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			if (start) begin
				issuing_q <= 1'b1;
				rd_idx_q  <= '0;
			end else if (issuing_q) begin
				if (rd_stop) begin
					issuing_q <= 1'b0;
				end else begin
					rd_idx_q <= rd_idx_q + 1'b1;
				end
			end
			valid_s1 <= issuing_q;
			valid_s2 <= valid_s1 && (idx_s1 != '0);
			done_q   <= valid_s2 && (widx_s2 == cmd_q.last_idx);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cmd_q <= cmd;
		end
		idx_s1  <= rd_idx_q;
		mask_s1 <= rd_mask;
		if (valid_s1) begin
			if (idx_s1 == '0) begin
				prev_q <= '0;
			end else begin
				prev_q <= cur_q;
			end
			cur_q   <= c_val;
			sum_s2  <= {2'b00, prev_q} + {2'b00, cur_q} + {2'b00, c_val};
			widx_s2 <= idx_m1[chpc_pkg::AW-1:0];
		end
		if (valid_s2 && (widx_s2 == '0)) begin
			res0_q <= wval;
		end
	end

	assign sts.done = done_q;
	assign sts.res0 = res0_q;

`ifndef ASSERT_OFF
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> (!issuing_q && !valid_s1 && !valid_s2))
		else $error("sweep started while one is in flight");
	a_write_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (widx_s2 <= cmd_q.last_idx))
		else $error("write beyond sweep range");
	a_read_range: assert property (@(posedge clk) disable iff (!arst_n)
		issuing_q |-> (rd_idx_q <= ({1'b0, cmd_q.last_idx} + 1'b1)))
		else $error("read index ran past sweep range");
`endif

endmodule

// File: rtl/constrained_height_path_count_core.sv
// top level of the constrained height path counter
// usage:
// - input channel (in_valid, in_stall, is_free, fixed_height) carries one column per word;
//   in_stall stays high while a column is being worked on
// - output channel (out_valid, out_stall, path_count) carries one word at the last column
//   of a run: the path count mod 1000000007, or 0 when the run broke a constraint
// - cfg channel (cfg_valid, cfg_ready, cfg_data) writes column_count; cfg_ready is always
//   high, write it only between runs or while no column is in work
// - each column that sweeps (all but a later fixed column above the cap) sweeps the count memory
//   once from height zero up to the written extent, or for a later column up to the larger
//   of that extent and the cap (or the fixed height), one entry a cycle through the single
//   read port and single write port; a later fixed column above the cap takes no sweep
// - the result word is registered once the final column is done and the output register is free
// - a result held by out_stall does not block the next column; the block waits only if
//   another result is ready before the held one is taken
// - reset clears the column counter and fail flag, sets column_count to 1, and takes no
//   clearing pass: the first column of every run rewrites the count memory
module constrained_height_path_count_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        is_free,
	input  logic [chpc_pkg::HW-1:0]     fixed_height,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [chpc_pkg::CW-1:0]     path_count,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [chpc_pkg::COLW-1:0]   cfg_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FIN
	} state_t;

	state_t                       state_q;
	logic [chpc_pkg::COLW-1:0]    col_count_q;
	logic [chpc_pkg::IDXW-1:0]    col_idx_q;
	logic                         run_failed_q;
	logic [chpc_pkg::AW-1:0]      hi_q;     // entries above this index read as zero
	logic                         last_q;
	logic                         out_valid_q;
	logic [chpc_pkg::CW-1:0]      path_count_q;

	logic                         accept;
	logic [chpc_pkg::COLW-1:0]    cols_eff;
	logic [chpc_pkg::COLW-1:0]    cols_m1;
	logic [chpc_pkg::AW-1:0]      cap;
	logic                         is_last;
	logic                         is_start;
	logic                         h_ok;
	logic                         need_sweep;
	logic                         fail_next;
	logic [chpc_pkg::AW-1:0]      h_short;
	logic                         out_free;
	logic                         out_load;

	chpc_pkg::sweep_cmd_t         cmd;
	chpc_pkg::sweep_sts_t         sts;

	assign accept    = in_valid && (state_q == ST_IDLE);
	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign path_count = path_count_q;

	// column count clamp: zero acts as one, above the maximum acts as the maximum
	always_comb begin
		if (col_count_q == '0) begin
			cols_eff = chpc_pkg::COLW'(1);
		end else if (col_count_q > chpc_pkg::COLW'(chpc_pkg::MAX_COLUMNS)) begin
			cols_eff = chpc_pkg::COLW'(chpc_pkg::MAX_COLUMNS);
		end else begin
			cols_eff = col_count_q;
		end
	end

	assign cols_m1  = cols_eff - 1'b1;
	assign cap      = cols_m1[chpc_pkg::AW:1];
	assign is_last  = (chpc_pkg::COLW'(col_idx_q) + 1'b1) >= cols_eff;
	assign is_start = (col_idx_q == '0);
	assign h_ok     = fixed_height <= chpc_pkg::HW'(cap);
	assign h_short  = fixed_height[chpc_pkg::AW-1:0];

	// a fixed column above the cap leaves the counts alone
	assign need_sweep = is_start || is_free || h_ok;

	always_comb begin
		if (is_start) begin
			fail_next = !is_free && (fixed_height != '0);
		end else begin
			fail_next = run_failed_q || (!is_free && !h_ok);
		end
		if (is_last && !is_free && (fixed_height != '0)) begin
			fail_next = 1'b1;
		end
	end

	// sweep command: range covers the old extent so stale entries get cleared
	always_comb begin
		cmd.hi  = hi_q;
		cmd.cap = cap;
		cmd.tgt = h_short;
		if (is_start) begin
			cmd.mode     = chpc_pkg::MODE_START;
			cmd.last_idx = hi_q;
		end else if (is_free) begin
			cmd.mode     = chpc_pkg::MODE_FREE;
			cmd.last_idx = (hi_q > cap) ? hi_q : cap;
		end else begin
			cmd.mode     = chpc_pkg::MODE_FIXED;
			cmd.last_idx = (hi_q > h_short) ? hi_q : h_short;
		end
	end

	// output register is free when empty or being taken this cycle
	assign out_free = !out_valid_q || !out_stall;
	// final column done and the output register can take its word
	assign out_load = (state_q == ST_FIN) && last_q && out_free;

	chpc_sweep u_sweep (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept && need_sweep),
		.cmd    (cmd),
		.sts    (sts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			col_count_q  <= chpc_pkg::COLW'(1);
			col_idx_q    <= '0;
			run_failed_q <= 1'b0;
			hi_q         <= '0;
			last_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			path_count_q <= '0;
		end else begin
			if (cfg_valid) begin
				col_count_q <= cfg_data;
			end
			// load a new word, or drop the one taken downstream
			if (out_load) begin
				out_valid_q  <= 1'b1;
				path_count_q <= run_failed_q ? '0 : sts.res0;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						run_failed_q <= fail_next;
						last_q       <= is_last;
						col_idx_q    <= is_last ? '0 : col_idx_q + 1'b1;
						if (is_start) begin
							hi_q <= '0;
						end else if (is_free) begin
							hi_q <= cap;
						end else if (h_ok) begin
							hi_q <= h_short;
						end
						state_q <= need_sweep ? ST_RUN : ST_FIN;
					end
				end
				ST_RUN: begin
					if (sts.done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!last_q || out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_done_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		sts.done |-> (state_q == ST_RUN))
		else $error("sweep done outside of run state");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != ST_IDLE))
		else $error("accepted column left the block idle");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (path_count_q < chpc_pkg::PRIME))
		else $error("path count not reduced");
`endif

endmodule
